/* src/cnb_pkg.sv */
`default_nettype none
package cnb_pkg;
    localparam int NUM_CLASSES    = 8;
    localparam int MAX_FEATURES   = 8;
    localparam int MAX_CATEGORIES = 16;
    localparam int COUNT_WIDTH    = 16;

    localparam int CLASS_W     = 3;
    localparam int FEAT_W      = 3;
    localparam int CAT_W       = 4;
    localparam int ADDR_W      = CLASS_W + FEAT_W + CAT_W;
    localparam int STORE_DEPTH = NUM_CLASSES * MAX_FEATURES * MAX_CATEGORIES;

    localparam int LOG_IN_W = 17;
    localparam int EXP_W    = 5;
    localparam int LOG_W    = EXP_W + 8;
    localparam int ACC_W    = 20;
    localparam int SCORE_W  = 17;

    localparam logic [1:0] KIND_TRAIN  = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] REG_ALPHA    = 2'd0;
    localparam logic [1:0] REG_CATEGORY = 2'd1;
    localparam logic [1:0] REG_FEATURE  = 2'd2;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    typedef struct packed {
        logic                start;
        logic [LOG_IN_W-1:0] x;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } log_rsp_t;
endpackage
`default_nettype wire

/* src/cnb_ram.sv */
`default_nettype none
module cnb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/cnb_log2.sv */
`default_nettype none
module cnb_log2
    import cnb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire log_req_t req,
    output log_rsp_t      rsp
);
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2:0]       iter_reg, iter_next;
    logic [31:0]      m_reg, m_next;
    logic [EXP_W-1:0] e_reg, e_next;
    logic [7:0]       frac_reg, frac_next;
    logic [EXP_W-1:0] msb;
    logic [63:0]      prod;
    logic [32:0]      sq;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < LOG_IN_W; i++)
        begin
            if (req.x[i])
            begin
                msb = EXP_W'(i);
            end
        end
    end

    assign prod = 64'(m_reg) * 64'(m_reg);
    assign sq   = prod[63:31];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        m_next    = m_reg;
        e_next    = e_reg;
        frac_next = frac_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            e_next    = msb;
            m_next    = 32'(req.x) << (EXP_W'(31) - msb);
            frac_next = '0;
        end
        else if (busy_reg)
        begin
            // square the mantissa; a square of 2.0 or more yields a one bit
            if (sq[32])
            begin
                m_next    = sq[32:1];
                frac_next = {frac_reg[6:0], 1'b1};
            end
            else
            begin
                m_next    = sq[31:0];
                frac_next = {frac_reg[6:0], 1'b0};
            end
            iter_next = iter_reg + 3'd1;
            if (iter_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = {e_reg, frac_reg};
endmodule
`default_nettype wire

/* src/categorical_naive_bayes_engine.sv */
// Training item: a read and a write of the count memory per used feature.
// Query item: per trained class 2 + F log2 evaluations on the shared
// squaring unit.
// Clear item and reset: a clearing pass over all 1024 entries of the count memory, no item taken.
// Reset is asynchronous, active low; registers return to alpha 1, K 16, F 8.
`default_nettype none
module categorical_naive_bayes_engine
    import cnb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // class_id[2:0], labels[34:3], zero fill
    input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // predicted_class[2:0], best_score[19:3], zero fill
    output logic [0:0]       m_axis_tuser,  // no_model[0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_T_RD, ST_T_WR, ST_Q_CLASS, ST_Q_LN, ST_Q_LD,
        ST_Q_RD, ST_Q_RDW, ST_Q_LF, ST_Q_CMP, ST_Q_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [CLASS_W-1:0]      c_reg, c_next;
    logic [FEAT_W-1:0]       feat_reg, feat_next;
    logic [31:0]             labels_reg, labels_next;
    logic [COUNT_WIDTH-1:0]  cc_reg [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0]  cc_next [NUM_CLASSES];
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] best_reg, best_next;
    logic [CLASS_W-1:0]      best_c_reg, best_c_next;
    logic                    found_reg, found_next;
    logic                    ov_reg, ov_next;
    logic [CLASS_W-1:0]      oc_reg, oc_next;
    logic                    onm_reg, onm_next;
    logic [SCORE_W-1:0]      os_reg, os_next;
    logic [3:0]              alpha_reg;
    logic [4:0]              k_reg;
    logic [3:0]              nf_reg;

    logic [3:0]             alpha_eff;
    logic [4:0]             k_eff;
    logic [3:0]             nf_eff;
    logic [8:0]             ak;
    logic [CAT_W-1:0]       cur_label;
    logic [ADDR_W-1:0]      addr_cur;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] n_cur;
    logic                   last_feat;
    logic [16:0]            nf_log;
    log_req_t               lreq;
    log_rsp_t               lrsp;

    assign alpha_eff = (alpha_reg == 4'd0) ? 4'd1 : alpha_reg;
    assign k_eff     = (k_reg < 5'd2) ? 5'd2 : ((k_reg > 5'd16) ? 5'd16 : k_reg);
    assign nf_eff    = (nf_reg == 4'd0) ? 4'd1 : ((nf_reg > 4'd8) ? 4'd8 : nf_reg);
    assign ak        = 9'(alpha_eff) * 9'(k_eff);
    assign cur_label = labels_reg[{feat_reg, 2'b00} +: CAT_W];
    assign addr_cur  = {c_reg, feat_reg, cur_label};
    assign n_cur     = cc_reg[c_reg];
    assign last_feat = ({1'b0, feat_reg} == (nf_eff - 4'd1));
    assign nf_log    = 17'(nf_eff) * 17'(lrsp.value);

    cnb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(STORE_DEPTH)) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_cur),
        .rdata (ram_rdata)
    );

    cnb_log2 u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lreq),
        .rsp   (lrsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        c_next      = c_reg;
        feat_next   = feat_reg;
        labels_next = labels_reg;
        cc_next     = cc_reg;
        acc_next    = acc_reg;
        best_next   = best_reg;
        best_c_next = best_c_reg;
        found_next  = found_reg;
        ov_next     = ov_reg & ~m_axis_tready;
        oc_next     = oc_reg;
        onm_next    = onm_reg;
        os_next     = os_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_cur;
        ram_wdata   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
        lreq.start  = 1'b0;
        lreq.x      = 17'(n_cur);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    c_next      = s_axis_tdata[2:0];
                    labels_next = s_axis_tdata[34:3];
                    feat_next   = '0;
                    case (s_axis_tuser)
                        KIND_TRAIN:
                        begin
                            if (cc_reg[s_axis_tdata[2:0]] != '1)
                            begin
                                cc_next[s_axis_tdata[2:0]] = cc_reg[s_axis_tdata[2:0]] + 1'b1;
                            end
                            state_next = ST_T_RD;
                        end
                        KIND_QUERY:
                        begin
                            c_next     = '0;
                            found_next = 1'b0;
                            best_next  = '0;
                            best_c_next = '0;
                            state_next = ST_Q_CLASS;
                        end
                        KIND_CLEAR:
                        begin
                            for (int i = 0; i < NUM_CLASSES; i++)
                            begin
                                cc_next[i] = '0;
                            end
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_T_RD:
            begin
                state_next = ST_T_WR;
            end
            ST_T_WR:
            begin
                ram_we = 1'b1;
                if (last_feat)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    feat_next  = feat_reg + 1'b1;
                    state_next = ST_T_RD;
                end
            end
            ST_Q_CLASS:
            begin
                if (n_cur == '0)
                begin
                    if (c_reg == CLASS_W'(NUM_CLASSES - 1))
                    begin
                        state_next = ST_Q_OUT;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    lreq.start = 1'b1;
                    state_next = ST_Q_LN;
                end
            end
            ST_Q_LN:
            begin
                if (lrsp.done)
                begin
                    acc_next   = ACC_W'(lrsp.value);
                    lreq.start = 1'b1;
                    lreq.x     = 17'(n_cur) + 17'(ak);
                    state_next = ST_Q_LD;
                end
            end
            ST_Q_LD:
            begin
                if (lrsp.done)
                begin
                    acc_next   = acc_reg - $signed(ACC_W'(nf_log));
                    feat_next  = '0;
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_RD:
            begin
                state_next = ST_Q_RDW;
            end
            ST_Q_RDW:
            begin
                lreq.start = 1'b1;
                lreq.x     = 17'(ram_rdata) + 17'(alpha_eff);
                state_next = ST_Q_LF;
            end
            ST_Q_LF:
            begin
                if (lrsp.done)
                begin
                    acc_next = acc_reg + $signed(ACC_W'(lrsp.value));
                    if (last_feat)
                    begin
                        state_next = ST_Q_CMP;
                    end
                    else
                    begin
                        feat_next  = feat_reg + 1'b1;
                        state_next = ST_Q_RD;
                    end
                end
            end
            ST_Q_CMP:
            begin
                if (!found_reg || (acc_reg > best_reg))
                begin
                    found_next  = 1'b1;
                    best_next   = acc_reg;
                    best_c_next = c_reg;
                end
                if (c_reg == CLASS_W'(NUM_CLASSES - 1))
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_Q_CLASS;
                end
            end
            ST_Q_OUT:
            begin
                // hold until the output register is free
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next  = 1'b1;
                    oc_next  = best_c_reg;
                    onm_next = ~found_reg;
                    if (best_reg < -ACC_W'(65536))
                    begin
                        os_next = SCORE_W'(-65536);
                    end
                    else if (best_reg > ACC_W'(65535))
                    begin
                        os_next = SCORE_W'(65535);
                    end
                    else
                    begin
                        os_next = best_reg[SCORE_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            alpha_reg <= 4'd1;
            k_reg     <= 5'd16;
            nf_reg    <= 4'd8;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                cc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            cc_reg    <= cc_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA:    alpha_reg <= cfg_data[3:0];
                    REG_CATEGORY: k_reg     <= cfg_data;
                    REG_FEATURE:  nf_reg    <= cfg_data[3:0];
                    default:      alpha_reg <= alpha_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        feat_reg   <= feat_next;
        labels_reg <= labels_next;
        acc_reg    <= acc_next;
        best_reg   <= best_next;
        best_c_reg <= best_c_next;
        found_reg  <= found_next;
        oc_reg     <= oc_next;
        onm_reg    <= onm_next;
        os_reg     <= os_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'b0, os_reg, oc_reg};
    assign m_axis_tuser  = onm_reg;
endmodule
`default_nettype wire

/* tb/sv/cnb_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module cnb_checker
    import cnb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic [2:0]  cls;
        logic        no_model;
        logic [16:0] score;
    } verdict_t;

    int unsigned label_tally [NUM_CLASSES][MAX_FEATURES][MAX_CATEGORIES];
    int unsigned class_tally [NUM_CLASSES];
    logic [3:0] alpha_reg;
    logic [4:0] cat_reg;
    logic [3:0] feat_reg;
    verdict_t   verdicts[$];

    assign pending = verdicts.size();

    // log2 in Q8.8 by repeated squaring of the mantissa
    function automatic longint log2_fix(longint unsigned x);
        int e;
        longint unsigned m;
        longint frac;
        e = 0;
        frac = 0;
        if (x == 0)
            return 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
        for (int i = 0; i < 8; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(e) * 256 + frac;
    endfunction

    task automatic apply_item(logic [1:0] kind, logic [2:0] cls, logic [31:0] labels);
        longint unsigned a;
        longint unsigned k;
        int nf;
        longint s;
        longint best;
        bit found;
        int best_c;
        int lab;
        verdict_t v;
        a = (alpha_reg == 0) ? 1 : alpha_reg;
        k = (cat_reg < 2) ? 2 : (cat_reg > MAX_CATEGORIES) ? MAX_CATEGORIES : cat_reg;
        nf = (feat_reg < 1) ? 1 : (feat_reg > MAX_FEATURES) ? MAX_FEATURES : feat_reg;
        found = 0;
        best = 0;
        best_c = 0;
        if (kind == KIND_CLEAR)
        begin
            label_tally = '{default: '{default: '{default: 0}}};
            class_tally = '{default: 0};
        end
        else if (kind == KIND_TRAIN)
        begin
            if (class_tally[cls] < 65535)
                class_tally[cls]++;
            for (int f = 0; f < nf; f++)
            begin
                lab = labels[4*f +: 4];
                if (label_tally[cls][f][lab] < 65535)
                    label_tally[cls][f][lab]++;
            end
        end
        else if (kind == KIND_QUERY)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (class_tally[c] == 0)
                    continue;
                s = log2_fix(class_tally[c]) - longint'(nf) * log2_fix(class_tally[c] + a * k);
                for (int f = 0; f < nf; f++)
                begin
                    lab = labels[4*f +: 4];
                    s += log2_fix(label_tally[c][f][lab] + a);
                end
                if (!found || s > best)
                begin
                    found = 1;
                    best = s;
                    best_c = c;
                end
            end
            if (best < -65536)
                best = -65536;
            if (best > 65535)
                best = 65535;
            v.cls = best_c[2:0];
            v.no_model = !found;
            v.score = best[16:0];
            verdicts = {verdicts, v};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            label_tally = '{default: '{default: '{default: 0}}};
            class_tally = '{default: 0};
            alpha_reg = 1;
            cat_reg = 16;
            feat_reg = 8;
            verdicts.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.cls = m_axis_tdata[2:0];
                got.score = m_axis_tdata[19:3];
                got.no_model = m_axis_tuser[0];
                if (verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (got.cls !== want.cls)
                    begin
                        $display("%0t: predicted_class expected %0d actual %0d",
                                 $realtime, want.cls, got.cls);
                        fail_count++;
                    end
                    if (got.no_model !== want.no_model)
                    begin
                        $display("%0t: no_model expected %0d actual %0d",
                                 $realtime, want.no_model, got.no_model);
                        fail_count++;
                    end
                    if (got.score !== want.score)
                    begin
                        $display("%0t: best_score expected %0d actual %0d", $realtime,
                                 $signed(want.score), $signed(got.score));
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_item(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[34:3]);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA:    alpha_reg = cfg_data[3:0];
                    REG_CATEGORY: cat_reg = cfg_data;
                    REG_FEATURE:  feat_reg = cfg_data[3:0];
                    default:      ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

/* tb/sv/tb_categorical_naive_bayes_engine.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_categorical_naive_bayes_engine;
    import cnb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // class_id[2:0], labels[34:3], zero fill
    logic [1:0]  s_axis_tuser;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // predicted_class[2:0], best_score[19:3], zero fill
    logic [0:0]  m_axis_tuser;   // no_model[0]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          hold_sink;

    categorical_naive_bayes_engine dut (.*);

    cnb_checker u_checker (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 8000000)
        begin
            $display("** categorical_naive_bayes_engine: FAILED **");
            $finish;
        end
    end

    // sink: random stalls, one long hold-off once hold_sink is set
    initial
    begin
        int gap;
        bit held;
        held = 0;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink && !held)
            begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge clk);
                held = 1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    task automatic send_item(logic [1:0] kind, logic [2:0] cls, logic [31:0] labels,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {5'd0, labels, cls};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // drain results, then allow a full clearing pass to finish
    task automatic settle();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    // labels drawn from 0..k-1 mostly, any nibble sometimes
    function automatic logic [31:0] rand_labels(int k);
        logic [31:0] l;
        for (int i = 0; i < 8; i++)
            l[4*i +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, k-1));
        return l;
    endfunction

    initial
    begin
        int k;
        int r;
        logic [1:0] kind;
        bit burst;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        hold_sink = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        repeat (1100) @(posedge clk);

        // directed: empty model, odd kind, extremes, ties, clear
        send_item(KIND_QUERY, 3'd5, 32'h0, 0);
        send_item(KIND_UNUSED, 3'd2, 32'hFFFF_FFFF, 0);
        send_item(KIND_QUERY, 3'd0, 32'hFFFF_FFFF, 0);
        send_item(KIND_TRAIN, 3'd0, 32'h0, 0);
        send_item(KIND_TRAIN, 3'd7, 32'hFFFF_FFFF, 0);
        send_item(KIND_QUERY, 3'd0, 32'h0, 0);
        send_item(KIND_QUERY, 3'd0, 32'hFFFF_FFFF, 0);
        send_item(KIND_TRAIN, 3'd3, 32'h0, 0);
        send_item(KIND_QUERY, 3'd7, 32'h0, 0);
        send_item(KIND_QUERY, 3'd1, 32'h1234_5678, 0);
        send_item(KIND_QUERY, 3'd1, 32'hA5A5_5A5A, 0);
        send_item(KIND_CLEAR, 3'd0, 32'h0, 0);
        send_item(KIND_QUERY, 3'd0, 32'h0, 0);
        settle();
        write_reg(REG_ALPHA, 5'd0);
        write_reg(REG_CATEGORY, 5'd0);
        write_reg(REG_FEATURE, 5'd0);
        write_reg(REG_UNUSED, 5'd9);
        send_item(KIND_TRAIN, 3'd2, 32'hFFFF_FFFF, 0);
        send_item(KIND_TRAIN, 3'd4, 32'h1111_1111, 0);
        send_item(KIND_QUERY, 3'd0, 32'hFFFF_FFFF, 0);
        send_item(KIND_QUERY, 3'd0, 32'h0000_0001, 0);
        settle();
        write_reg(REG_ALPHA, 5'd15);
        write_reg(REG_CATEGORY, 5'd31);
        write_reg(REG_FEATURE, 5'd15);
        send_item(KIND_QUERY, 3'd0, 32'hFFFF_FFFF, 0);
        send_item(KIND_CLEAR, 3'd0, 32'h0, 0);

        // random phases with changing settings
        for (int phase = 0; phase < 9; phase++)
        begin
            settle();
            case (phase)
                0: begin write_reg(REG_ALPHA, 5'd1); write_reg(REG_CATEGORY, 5'd2);
                         write_reg(REG_FEATURE, 5'd1); end
                1: begin write_reg(REG_ALPHA, 5'd15); write_reg(REG_CATEGORY, 5'd16);
                         write_reg(REG_FEATURE, 5'd8); end
                2: begin write_reg(REG_ALPHA, 5'd1); write_reg(REG_CATEGORY, 5'd16);
                         write_reg(REG_FEATURE, 5'd8); end
                default: begin
                    write_reg(REG_ALPHA, 5'($urandom_range(0, 15)));
                    write_reg(REG_CATEGORY, 5'($urandom_range(0, 31)));
                    write_reg(REG_FEATURE, 5'($urandom_range(0, 15)));
                end
            endcase
            k = (phase == 0) ? 2 : 16;
            if (phase == 4)
                hold_sink = 1;
            for (int i = 0; i < 180; i++)
            begin
                r = $urandom_range(0, 99);
                kind = (r < 55) ? KIND_TRAIN : (r < 97) ? KIND_QUERY :
                       (r < 98) ? KIND_CLEAR : KIND_UNUSED;
                burst = (phase == 4);
                send_item(kind, 3'($urandom), rand_labels(k), burst);
            end
        end
        settle();
        s_axis_tvalid <= 0;
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** categorical_naive_bayes_engine: PASSED **");
        else
            $display("** categorical_naive_bayes_engine: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
